[hdl/wsd_pkg.sv]
// Shared types, codes and constants of the work-stealing task dispatcher.
package wsd_pkg;

    localparam int NUM_WORKERS               = 4;
    localparam int WORKER_ID_W               = 2;
    localparam int TASK_WIDTH                = 32;
    localparam int ACTIVE_W                  = 3;
    localparam int PENDING_W                 = 8;
    localparam int WORKER_QUEUE_DEPTH_DEF    = 16;
    localparam int OVERFLOW_QUEUE_DEPTH_DEF  = 64;
    localparam int CFG_INDEX_W               = 2;
    localparam int CFG_DATA_W                = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_WORKERS_IN_USE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHUT_DOWN      = 2'd1;

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_FETCH  = 1'b1;

    typedef enum logic [2:0] {
        ST_QUEUED_WORKER   = 3'd0,
        ST_QUEUED_OVERFLOW = 3'd1,
        ST_DROPPED         = 3'd2,
        ST_REJECTED        = 3'd3,
        ST_GIVEN           = 3'd4,
        ST_NONE            = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        SRC_OWN      = 2'd0,
        SRC_STOLEN   = 2'd1,
        SRC_OVERFLOW = 2'd2
    } source_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUBMIT,
        S_SCAN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic latch;
        logic submit;
        logic scan;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_fetch;
        logic scan_done;
    } ctl_sts_t;

endpackage

[hdl/wsd_ctrl.sv]
// Sequencer of the dispatcher: accept, submit or steal scan, result hand-off.
module wsd_ctrl
    import wsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SUBMIT;
                end
            end
            S_SUBMIT:
            begin
                // The latched command decides whether a scan is needed.
                if (sts.is_fetch)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            S_SUBMIT:
            begin
                cmd.submit = !sts.is_fetch;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_RESULT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hdl/wsd_datapath.sv]
// Queue memories, fill counters, configuration and result registers.
module wsd_datapath
    import wsd_pkg::*;
#(
    parameter int WORKER_QUEUE_DEPTH   = WORKER_QUEUE_DEPTH_DEF,
    parameter int OVERFLOW_QUEUE_DEPTH = OVERFLOW_QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctl_cmd_t               cmd,
    output ctl_sts_t               sts,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_cmd,
    input  logic [TASK_WIDTH-1:0]  in_task,
    input  logic [WORKER_ID_W-1:0] in_worker,
    output logic [2:0]             status,
    output logic [TASK_WIDTH-1:0]  task_out,
    output logic [1:0]             task_source,
    output logic [WORKER_ID_W-1:0] queue_number,
    output logic [PENDING_W-1:0]   pending_total
);

    localparam int WQD     = WORKER_QUEUE_DEPTH;
    localparam int OQD     = OVERFLOW_QUEUE_DEPTH;
    localparam int WH_W    = $clog2(WQD);
    localparam int WF_W    = $clog2(WQD + 1);
    localparam int OH_W    = $clog2(OQD);
    localparam int OF_W    = $clog2(OQD + 1);
    localparam int WA_W    = $clog2(NUM_WORKERS * WQD);
    localparam int SUM_W   = $clog2(NUM_WORKERS * WQD + OQD + 1) + 1;

    logic [TASK_WIDTH-1:0]  wk_mem [NUM_WORKERS * WQD];
    logic [TASK_WIDTH-1:0]  ov_mem [OQD];
    logic [TASK_WIDTH-1:0]  wk_rd_reg;
    logic [TASK_WIDTH-1:0]  ov_rd_reg;

    logic [WH_W-1:0]        head_reg [NUM_WORKERS];
    logic [WF_W-1:0]        fill_reg [NUM_WORKERS];
    logic [OH_W-1:0]        ov_head_reg;
    logic [OF_W-1:0]        ov_fill_reg;
    logic [WORKER_ID_W-1:0] rr_reg;
    logic [ACTIVE_W-1:0]    wiu_reg;
    logic                   shut_reg;

    logic                   cmd_reg;
    logic [TASK_WIDTH-1:0]  task_reg;
    logic [WORKER_ID_W-1:0] me_reg;
    logic [WORKER_ID_W-1:0] cand_reg;
    logic [ACTIVE_W-1:0]    step_reg;
    logic                   ovf_phase_reg;

    status_t                status_reg;
    source_t                src_reg;
    logic [WORKER_ID_W-1:0] qnum_reg;

    logic [ACTIVE_W-1:0]    n_act;
    logic [WORKER_ID_W-1:0] rr_idx;
    logic [WORKER_ID_W-1:0] rr_following;
    logic [WORKER_ID_W-1:0] cand_following;
    logic                   me_ok;
    logic                   wk_full;
    logic                   ov_full;
    logic [WH_W:0]          wk_tail_sum;
    logic [WH_W-1:0]        wk_tail;
    logic [OH_W:0]          ov_tail_sum;
    logic [OH_W-1:0]        ov_tail;
    logic [WA_W-1:0]        wk_waddr;
    logic [WA_W-1:0]        wk_raddr;
    logic                   wk_we;
    logic                   ov_we;
    logic                   wk_hit;
    logic                   ov_hit;
    logic                   can_steal;
    logic [SUM_W-1:0]       sum;

    // Reduces a worker number modulo the active count, at most NUM_WORKERS steps.
    function automatic logic [WORKER_ID_W-1:0] mod_active(
        input logic [WORKER_ID_W-1:0] v,
        input logic [ACTIVE_W-1:0]    n
    );
        logic [ACTIVE_W-1:0] r;
        r = ACTIVE_W'(v);
        for (int k = 0; k < NUM_WORKERS; k++)
        begin
            if (r >= n)
            begin
                r = r - n;
            end
        end
        return r[WORKER_ID_W-1:0];
    endfunction

    always_comb
    begin
        if (wiu_reg == '0)
        begin
            n_act = ACTIVE_W'(1);
        end
        else if (wiu_reg > ACTIVE_W'(NUM_WORKERS))
        begin
            n_act = ACTIVE_W'(NUM_WORKERS);
        end
        else
        begin
            n_act = wiu_reg;
        end
    end

    assign rr_idx       = mod_active(rr_reg, n_act);
    assign rr_following = (ACTIVE_W'(rr_idx) + 1'b1 == n_act) ? '0 : rr_idx + 1'b1;
    assign cand_following =
        (ACTIVE_W'(cand_reg) + 1'b1 == n_act) ? '0 : cand_reg + 1'b1;

    assign me_ok   = ACTIVE_W'(me_reg) < n_act;
    assign wk_full = fill_reg[rr_idx] == WF_W'(WQD);
    assign ov_full = ov_fill_reg == OF_W'(OQD);

    // Tail is head plus fill, which stays below twice the depth.
    always_comb
    begin
        wk_tail_sum = (WH_W+1)'(head_reg[rr_idx]) + (WH_W+1)'(fill_reg[rr_idx]);
        if (wk_tail_sum >= (WH_W+1)'(WQD))
        begin
            wk_tail_sum = wk_tail_sum - (WH_W+1)'(WQD);
        end
        wk_tail = wk_tail_sum[WH_W-1:0];
        ov_tail_sum = (OH_W+1)'(ov_head_reg) + (OH_W+1)'(ov_fill_reg);
        if (ov_tail_sum >= (OH_W+1)'(OQD))
        begin
            ov_tail_sum = ov_tail_sum - (OH_W+1)'(OQD);
        end
        ov_tail = ov_tail_sum[OH_W-1:0];
    end

    assign wk_waddr = WA_W'(rr_idx) * WA_W'(WQD) + WA_W'(wk_tail);
    assign wk_raddr = WA_W'(cand_reg) * WA_W'(WQD) + WA_W'(head_reg[cand_reg]);

    assign wk_we = cmd.submit && !shut_reg && !wk_full;
    assign ov_we = cmd.submit && !shut_reg && wk_full && !ov_full;

    assign wk_hit    = cmd.scan && me_ok && !ovf_phase_reg && fill_reg[cand_reg] != '0;
    assign ov_hit    = cmd.scan && me_ok && ovf_phase_reg && ov_fill_reg != '0;
    assign can_steal = !shut_reg && (step_reg + 1'b1 < n_act);

    assign sts.is_fetch  = cmd_reg == CMD_FETCH;
    assign sts.scan_done = !me_ok || ovf_phase_reg || fill_reg[cand_reg] != '0;

    always_ff @(posedge clk)
    begin
        if (wk_we)
        begin
            wk_mem[wk_waddr] <= task_reg;
        end
        if (wk_hit)
        begin
            wk_rd_reg <= wk_mem[wk_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ov_we)
        begin
            ov_mem[ov_tail] <= task_reg;
        end
        if (ov_hit)
        begin
            ov_rd_reg <= ov_mem[ov_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            task_reg <= in_task;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WORKERS; w++)
            begin
                head_reg[w] <= '0;
                fill_reg[w] <= '0;
            end
            ov_head_reg   <= '0;
            ov_fill_reg   <= '0;
            rr_reg        <= '0;
            wiu_reg       <= ACTIVE_W'(NUM_WORKERS);
            shut_reg      <= 1'b0;
            cmd_reg       <= CMD_SUBMIT;
            me_reg        <= '0;
            cand_reg      <= '0;
            step_reg      <= '0;
            ovf_phase_reg <= 1'b0;
            status_reg    <= ST_NONE;
            src_reg       <= SRC_OWN;
            qnum_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_WORKERS_IN_USE: wiu_reg  <= cfg_data;
                    CFG_SHUT_DOWN:      shut_reg <= cfg_data[0];
                    default:            ;
                endcase
            end
            if (cmd.latch)
            begin
                cmd_reg       <= in_cmd;
                me_reg        <= in_worker;
                cand_reg      <= in_worker;
                step_reg      <= '0;
                ovf_phase_reg <= 1'b0;
                src_reg       <= SRC_OWN;
                qnum_reg      <= '0;
                status_reg    <= ST_NONE;
            end
            if (cmd.submit)
            begin
                if (shut_reg)
                begin
                    status_reg <= ST_REJECTED;
                end
                else
                begin
                    rr_reg <= rr_following;
                    if (!wk_full)
                    begin
                        fill_reg[rr_idx] <= fill_reg[rr_idx] + 1'b1;
                        status_reg       <= ST_QUEUED_WORKER;
                        qnum_reg         <= rr_idx;
                    end
                    else if (!ov_full)
                    begin
                        ov_fill_reg <= ov_fill_reg + 1'b1;
                        status_reg  <= ST_QUEUED_OVERFLOW;
                    end
                    else
                    begin
                        status_reg <= ST_DROPPED;
                    end
                end
            end
            if (cmd.scan && me_ok)
            begin
                if (wk_hit)
                begin
                    head_reg[cand_reg] <= (head_reg[cand_reg] == WH_W'(WQD - 1)) ?
                                          '0 : head_reg[cand_reg] + 1'b1;
                    fill_reg[cand_reg] <= fill_reg[cand_reg] - 1'b1;
                    status_reg         <= ST_GIVEN;
                    src_reg            <= (step_reg == '0) ? SRC_OWN : SRC_STOLEN;
                    qnum_reg           <= cand_reg;
                end
                else if (ov_hit)
                begin
                    ov_head_reg <= (ov_head_reg == OH_W'(OQD - 1)) ? '0 : ov_head_reg + 1'b1;
                    ov_fill_reg <= ov_fill_reg - 1'b1;
                    status_reg  <= ST_GIVEN;
                    src_reg     <= SRC_OVERFLOW;
                end
                else if (!ovf_phase_reg)
                begin
                    // Own or victim queue empty: next one, else overflow phase.
                    if (can_steal)
                    begin
                        cand_reg <= cand_following;
                        step_reg <= step_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_phase_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        sum = SUM_W'(ov_fill_reg);
        for (int w = 0; w < NUM_WORKERS; w++)
        begin
            sum = sum + SUM_W'(fill_reg[w]);
        end
    end

    assign pending_total = (sum > SUM_W'(255)) ? PENDING_W'(255) : sum[PENDING_W-1:0];

    assign status       = status_reg;
    assign task_source  = (status_reg == ST_GIVEN) ? src_reg : SRC_OWN;
    assign queue_number = qnum_reg;
    assign task_out     = (status_reg != ST_GIVEN) ? '0 :
                          (src_reg == SRC_OVERFLOW) ? ov_rd_reg : wk_rd_reg;

endmodule

[hdl/work_stealing_task_dispatcher.sv]
// Top level of the work-stealing task dispatcher.
//
// One task is handled at a time. An input transfer moves the sequencer from
// idle to the submit state; a submit then goes straight to the result state,
// while a fetch first passes through the steal scan. The scan checks one queue
// per cycle against the fill counters before a single read of the queue
// memory. The input is ready again in the cycle after the result transfer.
// pending_total counts all tasks held, including those left in inactive
// queues. The queue memories hold no reset state; only their heads and fill
// counts are cleared.
module work_stealing_task_dispatcher
    import wsd_pkg::*;
#(
    parameter int WORKER_QUEUE_DEPTH   = WORKER_QUEUE_DEPTH_DEF,
    parameter int OVERFLOW_QUEUE_DEPTH = OVERFLOW_QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   cmd,
    input  logic [TASK_WIDTH-1:0]  task_handle,
    input  logic [WORKER_ID_W-1:0] worker_index,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             status,
    output logic [TASK_WIDTH-1:0]  task_out,
    output logic [1:0]             task_source,
    output logic [WORKER_ID_W-1:0] queue_number,
    output logic [PENDING_W-1:0]   pending_total
);

    ctl_cmd_t ctl_cmd;
    ctl_sts_t ctl_sts;

    assign cfg_ready = 1'b1;

    wsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (ctl_sts),
        .cmd       (ctl_cmd)
    );

    wsd_datapath #(
        .WORKER_QUEUE_DEPTH   (WORKER_QUEUE_DEPTH),
        .OVERFLOW_QUEUE_DEPTH (OVERFLOW_QUEUE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctl_cmd),
        .sts           (ctl_sts),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_cmd        (cmd),
        .in_task       (task_handle),
        .in_worker     (worker_index),
        .status        (status),
        .task_out      (task_out),
        .task_source   (task_source),
        .queue_number  (queue_number),
        .pending_total (pending_total)
    );

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while a result is held");

    a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid)
        else $error("result shown in the cycle after an input transfer");

    a_result_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> (!out_valid && in_ready))
        else $error("result not retired after its transfer");

    a_task_zero_unless_given: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_GIVEN) |-> (task_out == '0 && task_source == '0))
        else $error("task fields set on a result without a task");
`endif

endmodule

[tb/sv/work_stealing_task_dispatcher_tb.sv]
// Self-checking testbench for the work-stealing task dispatcher.
`timescale 1ns / 1ps

module work_stealing_task_dispatcher_tb;
    import wsd_pkg::*;

    localparam int WQ_DEPTH = WORKER_QUEUE_DEPTH_DEF;
    localparam int OQ_DEPTH = OVERFLOW_QUEUE_DEPTH_DEF;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        status_t                status;
        logic [TASK_WIDTH-1:0]  task_out;
        logic [1:0]             task_source;
        logic [WORKER_ID_W-1:0] queue_number;
        logic [PENDING_W-1:0]   pending_total;
    } dispatch_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   cmd;
    logic [TASK_WIDTH-1:0]  task_handle;
    logic [WORKER_ID_W-1:0] worker_index;
    logic                   out_valid;
    logic                   out_ready;
    logic [2:0]             status;
    logic [TASK_WIDTH-1:0]  task_out;
    logic [1:0]             task_source;
    logic [WORKER_ID_W-1:0] queue_number;
    logic [PENDING_W-1:0]   pending_total;

    work_stealing_task_dispatcher DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .task_handle(task_handle), .worker_index(worker_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .task_out(task_out), .task_source(task_source),
        .queue_number(queue_number), .pending_total(pending_total)
    );

    // Predictor state.
    logic [TASK_WIDTH-1:0] wq_mem [NUM_WORKERS][WQ_DEPTH];
    int unsigned           wq_head [NUM_WORKERS];
    int unsigned           wq_count [NUM_WORKERS];
    logic [TASK_WIDTH-1:0] oq_mem [OQ_DEPTH];
    int unsigned           oq_head;
    int unsigned           oq_count;
    int unsigned           rr_ptr;
    logic [2:0]            active_reg;
    logic                  shutdown_reg;

    dispatch_result_t expected_results [$];
    int  mismatch_count;
    int  result_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;
    longint cycle_count;

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int unsigned active_workers();
        int unsigned n;
        n = active_reg;
        if (n == 0) n = 1;
        if (n > NUM_WORKERS) n = NUM_WORKERS;
        return n;
    endfunction

    function automatic int unsigned total_held();
        int unsigned t;
        t = oq_count;
        for (int i = 0; i < NUM_WORKERS; i++) t += wq_count[i];
        return (t > 255) ? 255 : t;
    endfunction

    function automatic bit take_from_worker(int unsigned q, output logic [TASK_WIDTH-1:0] t);
        if (wq_count[q] == 0) return 0;
        t = wq_mem[q][wq_head[q]];
        wq_head[q] = (wq_head[q] + 1) % WQ_DEPTH;
        wq_count[q]--;
        return 1;
    endfunction

    // Computes the dispatcher's answer for one command and updates the queues.
    function automatic dispatch_result_t dispatch(logic c, logic [TASK_WIDTH-1:0] h,
                                                  logic [WORKER_ID_W-1:0] w);
        dispatch_result_t r;
        int unsigned n, idx, victim;
        logic [TASK_WIDTH-1:0] t;
        r = '0;
        n = active_workers();
        if (c == CMD_SUBMIT)
        begin
            if (shutdown_reg)
                r.status = ST_REJECTED;
            else
            begin
                idx = rr_ptr % n;
                rr_ptr = (idx + 1) % n;
                if (wq_count[idx] < WQ_DEPTH)
                begin
                    wq_mem[idx][(wq_head[idx] + wq_count[idx]) % WQ_DEPTH] = h;
                    wq_count[idx]++;
                    r.status = ST_QUEUED_WORKER;
                    r.queue_number = WORKER_ID_W'(idx);
                end
                else if (oq_count < OQ_DEPTH)
                begin
                    oq_mem[(oq_head + oq_count) % OQ_DEPTH] = h;
                    oq_count++;
                    r.status = ST_QUEUED_OVERFLOW;
                end
                else
                    r.status = ST_DROPPED;
            end
        end
        else
        begin
            r.status = ST_NONE;
            if (w < n)
            begin
                if (take_from_worker(w, t))
                begin
                    r.status = ST_GIVEN;
                    r.task_source = SRC_OWN;
                    r.queue_number = w;
                    r.task_out = t;
                end
                else
                begin
                    if (!shutdown_reg)
                        for (int i = 1; i < n; i++)
                        begin
                            victim = (w + i) % n;
                            if (r.status != ST_GIVEN && take_from_worker(victim, t))
                            begin
                                r.status = ST_GIVEN;
                                r.task_source = SRC_STOLEN;
                                r.queue_number = WORKER_ID_W'(victim);
                                r.task_out = t;
                            end
                        end
                    if (r.status != ST_GIVEN && oq_count > 0)
                    begin
                        r.task_out = oq_mem[oq_head];
                        oq_head = (oq_head + 1) % OQ_DEPTH;
                        oq_count--;
                        r.status = ST_GIVEN;
                        r.task_source = SRC_OVERFLOW;
                    end
                end
            end
        end
        r.pending_total = PENDING_W'(total_held());
        return r;
    endfunction

    task automatic send_command(logic c, logic [TASK_WIDTH-1:0] h, logic [WORKER_ID_W-1:0] w);
        dispatch_result_t want;
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid     <= 1'b1;
        cmd          <= c;
        task_handle  <= h;
        worker_index <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = dispatch(c, h, w);
        expected_results = {expected_results, want};
        // The block takes no new input before this result retires anyway.
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (NUM_WORKERS + 8) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_WORKERS_IN_USE)
            active_reg = val;
        else
            shutdown_reg = val[0];
        @(posedge clk);
    endtask

    // Result checker; the receiver stalls at random and on a hold request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                dispatch_result_t got, want;
                got = {status_t'(status), task_out, task_source, queue_number, pending_total};
                result_count++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result: %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_directed();
        send_command(CMD_FETCH, '0, 2'd0);
        send_command(CMD_SUBMIT, 32'hFFFF_FFFF, 2'd0);
        send_command(CMD_SUBMIT, 32'h0000_0000, 2'd3);
        send_command(CMD_SUBMIT, 32'hA5A5_5A5A, 2'd0);
        send_command(CMD_FETCH, '0, 2'd0);
        send_command(CMD_FETCH, '0, 2'd0);
        send_command(CMD_FETCH, '0, 2'd3);
        send_command(CMD_FETCH, '0, 2'd1);
        // Fill worker queues past depth so overflow and drops occur.
        for (int i = 0; i < NUM_WORKERS * WQ_DEPTH + OQ_DEPTH + 4; i++)
            send_command(CMD_SUBMIT, $urandom, 2'($urandom));
        send_command(CMD_FETCH, '0, 2'd2);
    endtask

    task automatic test_config_corners();
        // Inactive queues keep their tasks; fetches by inactive workers see nothing.
        write_register(CFG_WORKERS_IN_USE, 3'd1);
        send_command(CMD_FETCH, '0, 2'd3);
        for (int i = 0; i < 20; i++) send_command(CMD_FETCH, '0, 2'd0);
        write_register(CFG_WORKERS_IN_USE, 3'd0);
        send_command(CMD_SUBMIT, $urandom, 2'd0);
        write_register(CFG_WORKERS_IN_USE, 3'd7);
        send_command(CMD_SUBMIT, $urandom, 2'd1);
        write_register(CFG_SHUT_DOWN, 3'd1);
        send_command(CMD_SUBMIT, $urandom, 2'd0);
        for (int i = 0; i < 30; i++) send_command(CMD_FETCH, '0, 2'($urandom));
        write_register(CFG_SHUT_DOWN, 3'd0);
        write_register(CFG_WORKERS_IN_USE, 3'd4);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
                write_register(CFG_WORKERS_IN_USE, 3'($urandom_range(1, 4)));
            send_command(logic'($urandom_range(99) < 52), $urandom, 2'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 40; i++) send_command(CMD_SUBMIT, $urandom, 2'd0);
        wait_drained();
        for (int i = 0; i < 40; i++) send_command(CMD_FETCH, '0, 2'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; cmd = 1'b0; task_handle = '0; worker_index = '0;
        out_ready = 1'b0;
        cycle_count = 0; mismatch_count = 0; result_count = 0; hold_cycles = 0;
        send_idle_pct = 30; recv_idle_pct = 87;
        for (int i = 0; i < NUM_WORKERS; i++)
        begin
            wq_head[i] = 0;
            wq_count[i] = 0;
        end
        oq_head = 0; oq_count = 0; rr_ptr = 0;
        active_reg = NUM_WORKERS; shutdown_reg = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_corners();
        test_random(500);
        send_idle_pct = 87; recv_idle_pct = 30;
        test_random(500);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        test_random(600);
        write_register(CFG_SHUT_DOWN, 3'd1);
        test_random(60);

        wait_drained();
        $display("Covered %0d results: submits, fetches, steals, overflow, drops,", result_count);
        $display("shutdown, active-count extremes and long output stalls.");
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
